[rtl/core/brq_pkg.sv]
package brq_pkg;

  // Ring geometry. The ring depth is a power of two so that a slot index
  // wraps by dropping the upper bits.
  localparam int Depth  = 1024;
  localparam int PtrW   = $clog2(Depth);
  localparam int IdxW   = 10;
  localparam int DataW  = 8;

  // Request opcodes.
  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_SET_HEAD = 3'd3,
    OP_CLEAR    = 3'd4
  } opcode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_CLEARED = 2'd2
  } status_t;

  typedef logic [PtrW-1:0] ptr_t;

  // Memory access issued for one request.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    ptr_t              addr;
    logic [DataW-1:0]  wr_data;
  } mem_req_t;

  // Everything known about a result except the byte read from the ring.
  typedef struct packed {
    status_t           status;
    logic              rd_ok;
    logic              is_empty;
    logic              is_full;
    logic [IdxW-1:0]   head_pos;
    logic              last_flag;
  } res_info_t;

endpackage

[rtl/core/byte_ring_queue_with_peek_unit.sv]
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | opcode, data_byte, index, burst_end
// out     | output    | out_valid/out_stall| status, data_out, is_empty, is_full,
//         |           |                    | head_pos, last_flag
//
// One request per cycle is accepted while in_stall is low; its result passes
// through the single-port ring memory's registered read and the output register.
// Synchronous active-low reset clears both pointers and the valid flags; the
// ring contents are not cleared and need no clearing pass.
// A stalled result holds in the output register while one more request is
// taken into the read stage; the input stalls only when both are occupied.
module byte_ring_queue_with_peek_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_opcode,
  input  logic [brq_pkg::DataW-1:0]  in_data_byte,
  input  logic [brq_pkg::IdxW-1:0]   in_index,
  input  logic                       in_burst_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [brq_pkg::DataW-1:0]  out_data_out,
  output logic                       out_is_empty,
  output logic                       out_is_full,
  output logic [brq_pkg::IdxW-1:0]   out_head_pos,
  output logic                       out_last_flag
);

  logic                       accept;
  logic                       advance;
  logic                       p_valid_r;
  brq_pkg::res_info_t         p_info_r;
  brq_pkg::res_info_t         res_info;
  brq_pkg::mem_req_t          mem_req;
  logic [brq_pkg::DataW-1:0]  rd_data;
  logic                       out_valid_r;
  brq_pkg::res_info_t         out_info_r;
  logic [brq_pkg::DataW-1:0]  out_data_r;

  // The read stage moves on whenever the output register is free or draining.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = p_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  brq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_opcode),
    .data_byte (in_data_byte),
    .index     (in_index),
    .burst_end (in_burst_end),
    .mem_req   (mem_req),
    .res_info  (res_info)
  );

  brq_ram #(
    .DATA_W (brq_pkg::DataW),
    .DEPTH  (brq_pkg::Depth)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .rd_en   (mem_req.rd_en),
    .addr    (mem_req.addr),
    .wr_data (mem_req.wr_data),
    .rd_data (rd_data)
  );

  // Read stage: holds the request's result while the memory read completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (accept) begin
      p_valid_r <= 1'b1;
    end else if (advance) begin
      p_valid_r <= 1'b0;
    end
    if (accept) begin
      p_info_r <= res_info;
    end
  end

  // Output register: takes the read stage and its byte from the memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= p_valid_r;
    end
    if (advance && p_valid_r) begin
      out_info_r <= p_info_r;
      out_data_r <= p_info_r.rd_ok ? rd_data : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_info_r.status;
  assign out_data_out  = out_data_r;
  assign out_is_empty  = out_info_r.is_empty;
  assign out_is_full   = out_info_r.is_full;
  assign out_head_pos  = out_info_r.head_pos;
  assign out_last_flag = out_info_r.last_flag;

  // A result that did not read the ring carries a zero byte.
  a_no_data_without_read : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_info_r.status != brq_pkg::ST_OK) |-> (out_data_r == '0))
    else $error("rejected result carries data");

  // The ring can never be empty and full at once.
  a_empty_full_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_info_r.is_empty && out_info_r.is_full))
    else $error("result reports empty and full together");

  // A cleared queue reports head zero and empty.
  a_cleared_is_empty : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_info_r.status == brq_pkg::ST_CLEARED) |->
      (out_info_r.head_pos == '0) && out_info_r.is_empty)
    else $error("cleared result not empty at head zero");

  // A memory read is only issued for a request that enters the read stage.
  a_read_only_on_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.rd_en || mem_req.wr_en) |=> p_valid_r)
    else $error("memory access without a request in the read stage");

endmodule

[rtl/core/brq_ram.sv]
module brq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Single port: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/brq_ctrl.sv]
module brq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [2:0]                    opcode,
  input  logic [brq_pkg::DataW-1:0]     data_byte,
  input  logic [brq_pkg::IdxW-1:0]      index,
  input  logic                          burst_end,
  output brq_pkg::mem_req_t             mem_req,
  output brq_pkg::res_info_t            res_info
);

  brq_pkg::ptr_t head_r, head_nxt;
  brq_pkg::ptr_t tail_r, tail_nxt;
  brq_pkg::ptr_t tail_inc;
  brq_pkg::ptr_t head_inc;
  brq_pkg::ptr_t peek_pos;
  brq_pkg::ptr_t set_pos;
  logic          empty;
  logic          full;
  logic          peek_in;
  logic          set_in;
  logic          set_oob;
  brq_pkg::status_t status;
  logic          rd_ok;

  // Wrapping increments and occupancy flags of the current pointers.
  assign tail_inc = (tail_r == brq_pkg::PtrW'(brq_pkg::Depth - 1)) ? '0 : tail_r + 1'b1;
  assign head_inc = (head_r == brq_pkg::PtrW'(brq_pkg::Depth - 1)) ? '0 : head_r + 1'b1;
  assign empty    = (head_r == tail_r);
  assign full     = (tail_inc == head_r);

  // Slot positions taken from the index field.
  assign peek_pos = brq_pkg::PtrW'(index % brq_pkg::Depth);
  assign set_pos  = brq_pkg::PtrW'(index);
  assign set_oob  = (32'(index) >= 32'(brq_pkg::Depth));

  // Occupied range checks: peek excludes the tail, set-head includes it.
  always_comb begin
    if (head_r < tail_r) begin
      peek_in = (peek_pos >= head_r) && (peek_pos < tail_r);
      set_in  = (set_pos >= head_r) && (set_pos <= tail_r);
    end else begin
      peek_in = (peek_pos >= head_r) || (peek_pos < tail_r);
      set_in  = (set_pos >= head_r) || (set_pos <= tail_r);
    end
  end

  // Decode of one request into pointer updates, status and memory access.
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    status          = brq_pkg::ST_REJECT;
    rd_ok           = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.addr    = head_r;
    mem_req.wr_data = data_byte;
    case (opcode)
      brq_pkg::OP_PUSH: begin
        mem_req.addr = tail_r;
        if (!full) begin
          tail_nxt      = tail_inc;
          status        = brq_pkg::ST_OK;
          mem_req.wr_en = accept;
        end
      end
      brq_pkg::OP_POP: begin
        if (!empty) begin
          head_nxt      = head_inc;
          status        = brq_pkg::ST_OK;
          rd_ok         = 1'b1;
          mem_req.rd_en = accept;
        end
      end
      brq_pkg::OP_PEEK: begin
        mem_req.addr = peek_pos;
        if (!empty && peek_in) begin
          status        = brq_pkg::ST_OK;
          rd_ok         = 1'b1;
          mem_req.rd_en = accept;
        end
      end
      brq_pkg::OP_SET_HEAD: begin
        if (set_oob) begin
          status = brq_pkg::ST_REJECT;
        end else if (empty) begin
          status = brq_pkg::ST_OK;
        end else if (set_in) begin
          head_nxt = set_pos;
          status   = brq_pkg::ST_OK;
        end else begin
          head_nxt = '0;
          tail_nxt = '0;
          status   = brq_pkg::ST_CLEARED;
        end
      end
      brq_pkg::OP_CLEAR: begin
        head_nxt = '0;
        tail_nxt = '0;
        status   = brq_pkg::ST_OK;
      end
      default: begin
        status = brq_pkg::ST_REJECT;
      end
    endcase
  end

  // Result flags reflect the pointers after the step.
  always_comb begin
    res_info.status    = status;
    res_info.rd_ok     = rd_ok;
    res_info.is_empty  = (head_nxt == tail_nxt);
    res_info.is_full   = (((tail_nxt == brq_pkg::PtrW'(brq_pkg::Depth - 1)) ? '0 :
                           tail_nxt + 1'b1) == head_nxt);
    res_info.head_pos  = brq_pkg::IdxW'(head_nxt);
    res_info.last_flag = burst_end;
  end

  // Pointer registers advance only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

endmodule
